FILE: rtl/core/frred_pkg.sv
package frred_pkg;

  // default operand width
  localparam int DATA_WIDTH_DEF = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take a new word, form magnitudes and sign
    logic strip;      // halve both operands, count a common factor of two
    logic gcd;        // one binary gcd step
    logic div_start;  // set up a restoring division
    logic div_sel;    // 0: numerator, 1: denominator
    logic div_step;   // one quotient bit
    logic save_qn;    // keep the numerator quotient
    logic load_out;   // move the finished result into the output register
  } frred_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic special;    // zero numerator or zero denominator
    logic both_even;  // both operands still even
    logic gcd_done;   // odd part of the gcd is settled
    logic div_done;   // all quotient bits produced
  } frred_status_t;

endpackage

FILE: rtl/core/frred_ctrl.sv
module frred_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  frred_pkg::frred_status_t status,
  output frred_pkg::frred_cmd_t    cmd
);
  import frred_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STRIP = 3'd1;
  localparam logic [2:0] S_GCD   = 3'd2;
  localparam logic [2:0] S_DIVN  = 3'd3;
  localparam logic [2:0] S_DIVD  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_STRIP;
        end
      end
      S_STRIP: begin
        if (status.special) begin
          state_next = S_FIN;
        end else if (status.both_even) begin
          cmd.strip = 1'b1;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (status.gcd_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b0;
          state_next    = S_DIVN;
        end else begin
          cmd.gcd = 1'b1;
        end
      end
      S_DIVN: begin
        if (status.div_done) begin
          cmd.save_qn   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DIVD: begin
        if (status.div_done) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/frred_dp.sv
module frred_dp #(
  parameter int DATA_WIDTH = frred_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic signed [DATA_WIDTH-1:0]  num_in,
  input  logic signed [DATA_WIDTH-1:0]  den_in,
  input  frred_pkg::frred_cmd_t          cmd,
  output frred_pkg::frred_status_t       status,
  output logic signed [DATA_WIDTH-1:0]  reduced_num,
  output logic        [DATA_WIDTH-2:0]  reduced_den,
  output logic                          den_zero
);
  import frred_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int KW = $clog2(W);
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] MAX_MAG = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]  a, b;        // gcd operands
  logic [W-1:0]  xn, xd;      // magnitudes kept for division
  logic [KW-1:0] kk;          // common factors of two
  logic          neg, dz, nz;
  logic [W-1:0]  rem, quo, qn;
  logic [CW-1:0] cnt;

  logic [W-1:0]  mag_n, mag_d;
  logic [W-1:0]  dividend;
  logic [W:0]    r2;
  logic          q_bit;
  logic [W-1:0]  num_mag, den_mag;

  assign mag_n = num_in[W-1] ? (~num_in + 1'b1) : num_in;
  assign mag_d = den_in[W-1] ? (~den_in + 1'b1) : den_in;

  assign dividend = (cmd.div_sel ? xd : xn) >> kk;
  assign r2       = {rem, quo[W-1]};
  assign q_bit    = (r2 >= {1'b0, a});

  assign status.special   = dz || nz;
  assign status.both_even = !a[0] && !b[0];
  assign status.gcd_done  = (b == '0);
  assign status.div_done  = (cnt == CW'(W));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= mag_n;
      b   <= mag_d;
      xn  <= mag_n;
      xd  <= mag_d;
      kk  <= '0;
      neg <= num_in[W-1] ^ den_in[W-1];
      dz  <= (mag_d == '0);
      nz  <= (mag_n == '0);
    end else if (cmd.strip) begin
      a  <= a >> 1;
      b  <= b >> 1;
      kk <= kk + 1'b1;
    end else if (cmd.gcd) begin
      if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a >= b) begin
        // keep the smaller in a, the difference in b
        a <= b;
        b <= a - b;
      end else begin
        b <= b - a;
      end
    end

    if (cmd.save_qn) begin
      qn <= quo;
    end

    if (cmd.div_start) begin
      quo <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= q_bit ? W'(r2 - {1'b0, a}) : r2[W-1:0];
      quo <= {quo[W-2:0], q_bit};
      cnt <= cnt + 1'b1;
    end
  end

  // a quotient of the most negative input may not fit: saturate
  assign num_mag = qn[W-1]  ? MAX_MAG : qn;
  assign den_mag = quo[W-1] ? MAX_MAG : quo;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (dz) begin
        reduced_num <= '0;
        reduced_den <= '0;
      end else if (nz) begin
        reduced_num <= '0;
        reduced_den <= (W-1)'(1);
      end else begin
        reduced_num <= neg ? (~num_mag + 1'b1) : num_mag;
        reduced_den <= den_mag[W-2:0];
      end
      den_zero <= dz;
    end
  end

endmodule

FILE: rtl/core/fraction_reducer.sv
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | num_in, den_in
// output   | out_valid / out_ready| reduced_num, reduced_den, den_zero
//
// one word at a time: load, then the common twos are stripped (at most W-1) and
// binary gcd steps run, then two W-bit restoring divisions (numerator, then
// denominator) and the output load follow; a zero operand skips strip, gcd and divisions
// the output register lets a new word in while the last result waits, and a
// finished result waits in the engine while out_ready stays low; rst clears state
module fraction_reducer #(
  parameter int DATA_WIDTH = frred_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  num_in,
  input  logic signed [DATA_WIDTH-1:0]  den_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  reduced_num,
  output logic        [DATA_WIDTH-2:0]  reduced_den,
  output logic                          den_zero
);
  import frred_pkg::*;

  frred_cmd_t    cmd;
  frred_status_t status;

  // sequencer: walks strip, gcd and the two divisions
  frred_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // operands, gcd datapath and divider, output register
  frred_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .num_in      (num_in),
    .den_in      (den_in),
    .cmd         (cmd),
    .status      (status),
    .reduced_num (reduced_num),
    .reduced_den (reduced_den),
    .den_zero    (den_zero)
  );

endmodule

FILE: dv/tb_fraction_reducer.sv
`timescale 1ns / 100ps

module tb_fraction_reducer;

  localparam int DW = frred_pkg::DATA_WIDTH_DEF;

  localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MAX_POS  = {1'b0, {(DW-1){1'b1}}};
  localparam logic        [DW-2:0] MAX_DEN  = {(DW-1){1'b1}};
  localparam logic        [63:0]   MAX_MAG  = (64'd1 << (DW-1)) - 64'd1;

  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM   = 1700;
  // receiver holds off once this many results have gone by
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_LEN   = 3000;
  localparam int DRAIN_WAIT = 400;

  // one reduced fraction as it leaves the block
  typedef struct packed {
    logic signed [DW-1:0] num;
    logic        [DW-2:0] den;
    logic                 zero;
  } fraction_t;

  // one row of the directed table: operands, and a typed-in result where obvious
  typedef struct {
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
    bit                   known;
    fraction_t            res;
  } frac_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] num_in    = '0;
  logic signed [DW-1:0] den_in    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] reduced_num;
  logic        [DW-2:0] reduced_den;
  logic                 den_zero;

  // travels with the word on the input so the monitor knows how to predict it
  bit        word_known  = 1'b0;
  fraction_t word_result = '0;

  fraction_t pending_fractions[$];
  int        mismatch_count = 0;
  int        results_seen   = 0;

  fraction_reducer #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .num_in     (num_in),
    .den_in     (den_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reduced_num(reduced_num),
    .reduced_den(reduced_den),
    .den_zero   (den_zero)
  );

  always #6 clk = ~clk;

  // directed words: zero denominators, zero numerators, extremes, sign cases,
  // then a few awkward ones left to the predictor
  frac_row_t dir_rows [N_DIRECTED] = '{
    '{'0,          '0,           1'b1, '{'0,        '0,      1'b1}},
    '{32'sd5,      '0,           1'b1, '{'0,        '0,      1'b1}},
    '{MOST_NEG,    '0,           1'b1, '{'0,        '0,      1'b1}},
    '{MAX_POS,     '0,           1'b1, '{'0,        '0,      1'b1}},
    '{'0,          32'sd7,       1'b1, '{'0,        31'd1,   1'b0}},
    '{'0,          -32'sd1,      1'b1, '{'0,        31'd1,   1'b0}},
    '{'0,          MOST_NEG,     1'b1, '{'0,        31'd1,   1'b0}},
    '{32'sd1,      32'sd1,       1'b1, '{32'sd1,    31'd1,   1'b0}},
    '{MAX_POS,     MAX_POS,      1'b1, '{32'sd1,    31'd1,   1'b0}},
    '{MOST_NEG,    MOST_NEG,     1'b1, '{32'sd1,    31'd1,   1'b0}},
    '{MOST_NEG,    32'sd1,       1'b1, '{-MAX_POS,  31'd1,   1'b0}},
    '{MOST_NEG,    -32'sd1,      1'b1, '{MAX_POS,   31'd1,   1'b0}},
    '{32'sd1,      MOST_NEG,     1'b1, '{-32'sd1,   MAX_DEN, 1'b0}},
    '{MAX_POS,     32'sd1,       1'b1, '{MAX_POS,   31'd1,   1'b0}},
    '{-MAX_POS,    -32'sd1,      1'b1, '{MAX_POS,   31'd1,   1'b0}},
    '{32'sd6,      32'sd4,       1'b1, '{32'sd3,    31'd2,   1'b0}},
    '{-32'sd6,     32'sd4,       1'b1, '{-32'sd3,   31'd2,   1'b0}},
    '{32'sd6,      -32'sd4,      1'b1, '{-32'sd3,   31'd2,   1'b0}},
    '{-32'sd6,     -32'sd4,      1'b1, '{32'sd3,    31'd2,   1'b0}},
    '{MAX_POS,     MOST_NEG,     1'b0, '{'0, '0, 1'b0}},
    '{MOST_NEG,    32'sd2,       1'b0, '{'0, '0, 1'b0}},
    '{32'sh4000_0000, 32'sh2000_0000, 1'b0, '{'0, '0, 1'b0}},
    // consecutive fibonacci numbers, coprime
    '{32'sd1836311903, 32'sd1134903170, 1'b0, '{'0, '0, 1'b0}},
    '{-32'sd1000000007, 32'sd998244353, 1'b0, '{'0, '0, 1'b0}},
    '{32'sd111546435, 32'sd223092870, 1'b0, '{'0, '0, 1'b0}}
  };

  // lowest terms by euclid on the exact magnitudes, saturating the
  // magnitude of the most negative value where it survives reduction
  function automatic fraction_t reduce_fraction(logic signed [DW-1:0] n,
                                                logic signed [DW-1:0] d);
    fraction_t     r;
    logic [DW-1:0] n_mag, d_mag, n_low;
    logic [63:0]   a, b, t, nq, dq;
    r = '0;
    n_mag = n[DW-1] ? (~n + 1'b1) : n;
    d_mag = d[DW-1] ? (~d + 1'b1) : d;
    if (d_mag == '0) begin
      r.zero = 1'b1;
      return r;
    end
    if (n_mag == '0) begin
      r.den = (DW-1)'(1);
      return r;
    end
    a = 64'(n_mag);
    b = 64'(d_mag);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    nq = 64'(n_mag);
    dq = 64'(d_mag);
    nq = nq / a;
    dq = dq / a;
    if (nq > MAX_MAG) nq = MAX_MAG;
    if (dq > MAX_MAG) dq = MAX_MAG;
    n_low = nq[DW-1:0];
    // sign goes on the numerator only
    r.num = (n[DW-1] ^ d[DW-1]) ? -n_low : n_low;
    r.den = dq[DW-2:0];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] flip_sign(logic signed [DW-1:0] x);
    return ($urandom_range(0, 1) == 1) ? -x : x;
  endfunction

  // random operand pair; mostly nonzero with real common factors so that the
  // strip, gcd and division phases all get exercised
  task automatic pick_operands(output logic signed [DW-1:0] n,
                               output logic signed [DW-1:0] d);
    int unsigned kind, g, a, b;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      n = $urandom;
      d = $urandom;
    end else if (kind < 45) begin
      // shared factor up to 16 bits
      g = $urandom_range(1, 65535);
      a = $urandom_range(1, 32767);
      b = $urandom_range(1, 32767);
      n = flip_sign(a * g);
      d = flip_sign(b * g);
    end else if (kind < 60) begin
      // odd factor times a power of two, heavy on the common twos
      g = ($urandom_range(1, 255) | 1) << $urandom_range(0, 15);
      a = $urandom_range(1, 255);
      b = $urandom_range(1, 255);
      n = flip_sign(a * g);
      d = flip_sign(b * g);
    end else if (kind < 68) begin
      n = flip_sign(1 << $urandom_range(0, DW-1));
      d = flip_sign(1 << $urandom_range(0, DW-1));
    end else if (kind < 76) begin
      n = flip_sign($urandom_range(0, 20));
      d = flip_sign($urandom_range(0, 20));
    end else if (kind < 80) begin
      n = $urandom;
      d = '0;
    end else if (kind < 84) begin
      n = '0;
      d = $urandom;
    end else if (kind < 90) begin
      // most negative value on one side or both
      n = MOST_NEG;
      d = ($urandom_range(0, 1) == 1) ? flip_sign(1 << $urandom_range(0, DW-1))
                                      : $urandom;
      if ($urandom_range(0, 1) == 1) begin
        d = n;
        n = $urandom;
      end
      if ($urandom_range(0, 3) == 0) d = MOST_NEG;
    end else begin
      n = flip_sign(MAX_POS - $urandom_range(0, 1000));
      d = flip_sign(MAX_POS - $urandom_range(0, 1000));
    end
  endtask

  // hold the word until it is taken, then return at the next falling edge
  task automatic offer_word(input logic signed [DW-1:0] n,
                            input logic signed [DW-1:0] d,
                            input bit known, input fraction_t res);
    num_in      <= n;
    den_in      <= d;
    word_known  <= known;
    word_result <= res;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender: bursts of words with random gaps between them
  initial begin
    int                   burst_left;
    int                   gap;
    logic signed [DW-1:0] n, d;
    burst_left = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      if (i < N_DIRECTED) begin
        offer_word(dir_rows[i].num, dir_rows[i].den, dir_rows[i].known, dir_rows[i].res);
      end else begin
        pick_operands(n, d);
        offer_word(n, d, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    // drain, then give a stray result time to show itself
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver: changing stall patterns, plus one long hold-off that backs the
  // block up until it refuses input
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    bit ready_bit;
    int phase;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    held = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 600);
        end
        mode_left--;
        phase++;
        case (mode)
          0: ready_bit = 1'b1;
          1: ready_bit = ($urandom_range(0, 1) == 1);
          2: ready_bit = ($urandom_range(0, 7) == 0);
          default: ready_bit = ((phase % 5) < 2);
        endcase
        out_ready <= ready_bit;
      end
    end
  end

  // monitor: check results against the oldest pending fraction, then record
  // the word taken on this edge
  always @(posedge clk) begin
    fraction_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_fractions.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing pending: %0d / %0d zero %0b",
                   $realtime, reduced_num, reduced_den, den_zero);
        end else begin
          want = pending_fractions.pop_front();
          if (reduced_num !== want.num) begin
            mismatch_count++;
            $display("%0t: reduced_num expected %0d actual %0d",
                     $realtime, want.num, reduced_num);
          end
          if (reduced_den !== want.den) begin
            mismatch_count++;
            $display("%0t: reduced_den expected %0d actual %0d",
                     $realtime, want.den, reduced_den);
          end
          if (den_zero !== want.zero) begin
            mismatch_count++;
            $display("%0t: den_zero expected %0b actual %0b",
                     $realtime, want.zero, den_zero);
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_fractions.push_back(word_known ? word_result
                                               : reduce_fraction(num_in, den_in));
      end
    end
  end

  // watchdog, several times the slowest legal run
  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
